// ===== hw/rtl/plin_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plin_pkg
// Shared widths, codes and types of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package plin_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int POINTS    = 64;
    localparam int IDX_W     = $clog2(POINTS);
    localparam int PCNT_W    = 7;
    localparam int ST_W      = 2;
    localparam int ALU_W     = DATA_W + 2;
    localparam int STEP_W    = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [PCNT_W-1:0] PCNT_RESET = PCNT_W'(2);

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // status codes
    localparam logic [ST_W-1:0] ST_INTERP = 2'd0;
    localparam logic [ST_W-1:0] ST_BELOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_ABOVE  = 2'd2;
    localparam logic [ST_W-1:0] ST_NOSEG  = 2'd3;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_RD_FIRST = 12'b0000_0000_0010,
        S_RD_LAST  = 12'b0000_0000_0100,
        S_WALK     = 12'b0000_0000_1000,
        S_SEG_DX   = 12'b0000_0001_0000,
        S_SEG_D    = 12'b0000_0010_0000,
        S_SEG_DY   = 12'b0000_0100_0000,
        S_SEG_ABS  = 12'b0000_1000_0000,
        S_MUL      = 12'b0001_0000_0000,
        S_DIV      = 12'b0010_0000_0000,
        S_ADJ      = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } t_state;

    // write port of the breakpoint table
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
    } t_tbl_wr;

endpackage
`default_nettype wire

// ===== hw/rtl/plin_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plin_if
// Valid/ready channels of the interpolator: request, response, configuration.
// ----------------------------------------------------------------------------
interface plin_req_if import plin_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [IDX_W-1:0]         point_index;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] y_value;

    modport source (output valid, req_type, point_index, x_value, y_value, input ready);
    modport sink   (input valid, req_type, point_index, x_value, y_value, output ready);
endinterface

interface plin_rsp_if import plin_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] y_result;
    logic [ST_W-1:0]          status;

    modport source (output valid, y_result, status, input ready);
    modport sink   (input valid, y_result, status, output ready);
endinterface

interface plin_cfg_if import plin_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PCNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/plin_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plin_table
// Breakpoint store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module plin_table import plin_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_tbl_wr           i_wr,
    input  wire logic [IDX_W-1:0]  i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_x,
    output logic      [DATA_W-1:0] o_rd_y
);

    logic [DATA_W-1:0] r_mem_x [POINTS];
    logic [DATA_W-1:0] r_mem_y [POINTS];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_x[i_wr.addr] <= i_wr.x;
            r_mem_y[i_wr.addr] <= i_wr.y;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_x <= r_mem_x[i_rd_addr];
        o_rd_y <= r_mem_y[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/piecewise_linear_interpolator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// Breakpoint table with clamped linear interpolation in signed Q16.16.
// ----------------------------------------------------------------------------
// Load transaction: accepted while idle, no response; loads may stream back to back.
// Query transaction: a clamped query completes once the first and last points are read; otherwise
//   the walk ends with no segment matched (n = points in use) or at segment k (1 to n-1), which
//   interpolates through 4 setup, 32 multiply and 32 divide steps on one adder.
// One query at a time: ready again as the response register loads.
// Reset (sync, active low) clears sequencer and response valid, sets point_count to 2.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_top import plin_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    plin_req_if.sink    i_req,
    plin_rsp_if.source  o_rsp,
    plin_cfg_if.sink    i_cfg
);

    // ---------------------------------------------------------------- state
    t_state r_state, n_state;

    logic [PCNT_W-1:0] r_point_count;

    // query operands and segment endpoints
    logic [DATA_W-1:0] r_x,  n_x;
    logic [DATA_W-1:0] r_x1, n_x1;
    logic [DATA_W-1:0] r_y1, n_y1;
    logic [DATA_W-1:0] r_x2, n_x2;
    logic [DATA_W-1:0] r_y2, n_y2;
    logic [IDX_W-1:0]  r_k,  n_k;

    // arithmetic working registers
    logic [DATA_W-1:0]   r_dx,  n_dx;
    logic [DATA_W-1:0]   r_d,   n_d;
    logic [ALU_W-1:0]    r_dy,  n_dy;
    logic                r_neg, n_neg;
    logic [DATA_W-1:0]   r_mag, n_mag;
    logic [2*DATA_W-1:0] r_p,   n_p;
    logic [STEP_W-1:0]   r_cnt, n_cnt;

    // result held until the response slot frees up
    logic [DATA_W-1:0] r_res, n_res;
    logic [ST_W-1:0]   r_st,  n_st;

    // response register
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_y,     n_out_y;
    logic [ST_W-1:0]   r_out_st,    n_out_st;

    // ---------------------------------------------------------------- table
    t_tbl_wr           tbl_wr;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_x;
    logic [DATA_W-1:0] rd_y;

    plin_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (rd_addr),
        .o_rd_x    (rd_x),
        .o_rd_y    (rd_y)
    );

    // ---------------------------------------------------------------- handshakes
    logic req_fire;
    logic rsp_fire;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_fire    = i_req.valid && i_req.ready;
    assign rsp_fire    = r_out_valid && o_rsp.ready;

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.y_result = r_out_y;
    assign o_rsp.status   = r_out_st;

    // A load beyond the table depth is dropped.
    always_comb begin
        tbl_wr.en   = req_fire && (i_req.req_type == REQ_LOAD)
                      && ({1'b0, i_req.point_index} < (IDX_W + 1)'(POINTS));
        tbl_wr.addr = i_req.point_index;
        tbl_wr.x    = i_req.x_value;
        tbl_wr.y    = i_req.y_value;
    end

    // Index of the last point in use: a count of zero acts as one, a count
    // beyond the table acts as the full table.
    logic [IDX_W-1:0] last_idx;

    always_comb begin
        if (r_point_count == '0) begin
            last_idx = '0;
        end else if (r_point_count > PCNT_W'(POINTS)) begin
            last_idx = IDX_W'(POINTS - 1);
        end else begin
            last_idx = IDX_W'(r_point_count - PCNT_W'(1));
        end
    end

    // ---------------------------------------------------------------- shared adder
    // One adder/subtractor serves segment setup, every multiply and divide
    // step, and the final offset from y1.
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic             alu_sub;
    logic [ALU_W-1:0] alu_sum;

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_SEG_DX: begin
                alu_a   = {{2{r_x[DATA_W-1]}},  r_x};
                alu_b   = {{2{r_x1[DATA_W-1]}}, r_x1};
                alu_sub = 1'b1;
            end
            S_SEG_D: begin
                alu_a   = {{2{r_x2[DATA_W-1]}}, r_x2};
                alu_b   = {{2{r_x1[DATA_W-1]}}, r_x1};
                alu_sub = 1'b1;
            end
            S_SEG_DY: begin
                alu_a   = {{2{r_y2[DATA_W-1]}}, r_y2};
                alu_b   = {{2{r_y1[DATA_W-1]}}, r_y1};
                alu_sub = 1'b1;
            end
            S_SEG_ABS: begin
                alu_b   = r_dy;
                alu_sub = 1'b1;
            end
            S_MUL: begin
                // add the multiplicand into the high half when the low bit is set
                alu_a = {2'b00, r_p[2*DATA_W-1:DATA_W]};
                alu_b = r_p[0] ? {2'b00, r_mag} : '0;
            end
            S_DIV: begin
                // trial subtract of the divisor from the shifted remainder
                alu_a   = {1'b0, r_p[2*DATA_W-1:DATA_W-1]};
                alu_b   = {2'b00, r_d};
                alu_sub = 1'b1;
            end
            S_ADJ: begin
                alu_a   = {{2{r_y1[DATA_W-1]}}, r_y1};
                alu_b   = {2'b00, r_p[DATA_W-1:0]};
                alu_sub = r_neg;
            end
            default: begin
            end
        endcase
    end

    assign alu_sum = alu_a + (alu_b ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);

    // ---------------------------------------------------------------- sequencer
    logic x_below_prev;
    logic x_below_rd;

    assign x_below_prev = $signed(r_x) < $signed(r_x1);
    assign x_below_rd   = $signed(r_x) < $signed(rd_x);

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_x2        = r_x2;
        n_y2        = r_y2;
        n_k         = r_k;
        n_dx        = r_dx;
        n_d         = r_d;
        n_dy        = r_dy;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_p         = r_p;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_st        = r_st;
        n_out_y     = r_out_y;
        n_out_st    = r_out_st;
        n_out_valid = r_out_valid && !rsp_fire;
        rd_addr     = '0;

        unique case (r_state)
            S_IDLE: begin
                // entry 0 is fetched here so it is ready when a query starts
                rd_addr = '0;
                if (req_fire && (i_req.req_type == REQ_EVAL)) begin
                    n_x     = i_req.x_value;
                    n_state = S_RD_FIRST;
                end
            end
            S_RD_FIRST: begin
                n_x1    = rd_x;
                n_y1    = rd_y;
                rd_addr = last_idx;
                n_state = S_RD_LAST;
            end
            S_RD_LAST: begin
                rd_addr = IDX_W'(1);
                n_k     = IDX_W'(1);
                if (x_below_prev) begin
                    n_res   = r_y1;
                    n_st    = ST_BELOW;
                    n_state = S_DONE;
                end else if (!x_below_rd) begin
                    n_res   = rd_y;
                    n_st    = ST_ABOVE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // entry k arrives while entry k+1 is fetched
                rd_addr = r_k + IDX_W'(1);
                if (!x_below_prev && x_below_rd) begin
                    n_x2    = rd_x;
                    n_y2    = rd_y;
                    n_state = S_SEG_DX;
                end else if (r_k == last_idx) begin
                    n_res   = ONE_Q;
                    n_st    = ST_NOSEG;
                    n_state = S_DONE;
                end else begin
                    n_x1 = rd_x;
                    n_y1 = rd_y;
                    n_k  = r_k + IDX_W'(1);
                end
            end
            S_SEG_DX: begin
                n_dx    = alu_sum[DATA_W-1:0];
                n_state = S_SEG_D;
            end
            S_SEG_D: begin
                n_d     = alu_sum[DATA_W-1:0];
                n_state = S_SEG_DY;
            end
            S_SEG_DY: begin
                n_dy    = alu_sum;
                n_neg   = alu_sum[ALU_W-1];
                n_mag   = alu_sum[DATA_W-1:0];
                n_state = S_SEG_ABS;
            end
            S_SEG_ABS: begin
                if (r_neg) begin
                    n_mag = alu_sum[DATA_W-1:0];
                end
                n_p     = {{DATA_W{1'b0}}, r_dx};
                n_cnt   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_p   = {alu_sum[DATA_W:0], r_p[DATA_W-1:1]};
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == '1) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // quotient stays below 2^32, so only the low half needs steps
                if (!alu_sum[ALU_W-1]) begin
                    n_p = {alu_sum[DATA_W-1:0], r_p[DATA_W-2:0], 1'b1};
                end else begin
                    n_p = {r_p[2*DATA_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == '1) begin
                    n_state = S_ADJ;
                end
            end
            S_ADJ: begin
                n_res   = alu_sum[DATA_W-1:0];
                n_st    = ST_INTERP;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the response register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_y     = r_res;
                    n_out_st    = r_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_point_count <= PCNT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_point_count <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_x1     <= n_x1;
        r_y1     <= n_y1;
        r_x2     <= n_x2;
        r_y2     <= n_y2;
        r_k      <= n_k;
        r_dx     <= n_dx;
        r_d      <= n_d;
        r_dy     <= n_dy;
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_p      <= n_p;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
        r_st     <= n_st;
        r_out_y  <= n_out_y;
        r_out_st <= n_out_st;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/plin_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plin_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module plin_checker import plin_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire logic              i_req_type,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire logic [DATA_W-1:0] i_rsp_y,
    input wire logic [ST_W-1:0]   i_rsp_st
);

    // a query occupies the block: no new transaction in the next cycle
    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_type == REQ_EVAL)) |=> !i_req_ready)
        else $error("request taken right after a query");

    // a load finishes in its own cycle
    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_type == REQ_LOAD)) |=> i_req_ready)
        else $error("load left the request channel busy");

    // a response only appears at the end of a query
    a_rsp_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !$past(i_req_ready))
        else $error("response without a query in flight");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_y) && $stable(i_rsp_st)))
        else $error("stalled response changed");

endmodule

bind piecewise_linear_interpolator_top plin_checker u_plin_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_y     (o_rsp.y_result),
    .i_rsp_st    (o_rsp.status)
);
`default_nettype wire
